FILE: rtl/core/bdqs_pkg.sv
// shared types and codes for the bounded deque with search
package bdqs_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_SEARCH     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP,
        OP_SEARCH,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t                     op;
        err_t                    err;
        logic signed [KEY_W-1:0] key;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_SEARCH,
        ST_REPORT
    } exec_state_t;

endpackage

FILE: rtl/core/bdqs_ifs.sv
// request and response channel interfaces
interface bdqs_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

interface bdqs_rsp_if #(parameter int COUNT_W = 5);
    logic               valid;
    logic               ready;
    logic               found;
    logic [COUNT_W-1:0] count;
    logic signed [31:0] front_key;
    logic signed [31:0] back_key;
    logic [1:0]         error;

    modport source (
        output valid, output found, output count, output front_key,
        output back_key, output error, input ready
    );
    modport sink (
        input valid, input found, input count, input front_key,
        input back_key, input error, output ready
    );
endinterface

FILE: rtl/core/bdqs_front.sv
// request classifier: tracks occupancy and flags full and empty errors
module bdqs_front
    import bdqs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = 5
)(
    input  logic          clk,
    input  logic          rst_n,
    bdqs_req_if.sink      request,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output cmd_t          cmd,
    output logic [CW-1:0] cmd_count
);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          is_full;
    logic          none_held;
    kind_t         kind;

    assign kind          = kind_t'(request.kind);
    assign is_full       = (count_reg == CW'(DEPTH));
    assign none_held     = (count_reg == '0);
    assign request.ready = cmd_ready;
    assign cmd_valid     = request.valid;

    always_comb
    begin
        cmd.op     = OP_REJECT;
        cmd.err    = ERR_OK;
        cmd.key    = request.value;
        count_next = count_reg;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (is_full)
                begin
                    cmd.err = ERR_FULL;
                end
                else
                begin
                    cmd.op     = (kind == KIND_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (none_held)
                begin
                    cmd.err = ERR_EMPTY;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                cmd.op = OP_SEARCH;
            end
        endcase
    end

    assign cmd_count = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (request.valid && cmd_ready)
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/bdqs_queue.sv
// two-entry command queue between classifier and executor
module bdqs_queue
    import bdqs_pkg::*;
#(
    parameter int WIDTH = 40
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       used_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (used_reg != 2'd2);
    assign rd_valid = (used_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            used_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                used_reg <= used_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                used_reg <= used_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/bdqs_exec.sv
// executor: ring store, front and back tracking, search scan, result register
module bdqs_exec
    import bdqs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = 5,
    parameter int IW    = 4
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cmd_t          cmd,
    input  logic [CW-1:0] cmd_count,
    bdqs_rsp_if.source    response
);

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;

    exec_state_t             state_reg;
    exec_state_t             state_next;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [IW-1:0]           front_idx_reg;
    logic [IW-1:0]           front_idx_next;
    logic [IW-1:0]           back_idx_reg;
    logic [IW-1:0]           back_idx_next;
    logic signed [KEY_W-1:0] front_key_reg;
    logic signed [KEY_W-1:0] front_key_next;
    logic signed [KEY_W-1:0] back_key_reg;
    logic signed [KEY_W-1:0] back_key_next;
    logic [IW-1:0]           scan_idx_reg;
    logic [IW-1:0]           scan_idx_next;
    logic [CW-1:0]           left_reg;
    logic [CW-1:0]           left_next;
    logic                    pend_reg;
    logic                    pend_next;
    logic                    hit_reg;
    logic                    hit_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    found_out_reg;
    logic [CW-1:0]           count_out_reg;
    logic signed [KEY_W-1:0] front_out_reg;
    logic signed [KEY_W-1:0] back_out_reg;
    err_t                    err_out_reg;

    logic                    take;
    logic                    slot_free;
    logic                    load_out;
    logic                    mem_we;
    logic [IW-1:0]           wr_addr;
    logic [IW-1:0]           rd_addr;
    logic                    was_empty;

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] i);
        return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] i);
        return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
    endfunction

    assign slot_free = !out_valid_reg || response.ready;
    assign was_empty = (cmd_count == CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_POP:    state_next = ST_POP_WAIT;
                        OP_SEARCH: state_next = ST_SEARCH;
                        default:   state_next = ST_REPORT;
                    endcase
                end
            end
            ST_POP_WAIT:
            begin
                state_next = ST_REPORT;
            end
            ST_SEARCH:
            begin
                if ((left_reg == '0) && !pend_reg)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:   cmd_ready = 1'b1;
            ST_REPORT: load_out  = slot_free;
            default:
            begin
                cmd_ready = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    assign take = cmd_valid && cmd_ready;

    // datapath
    always_comb
    begin
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        front_idx_next = front_idx_reg;
        back_idx_next  = back_idx_reg;
        front_key_next = front_key_reg;
        back_key_next  = back_key_reg;
        scan_idx_next  = scan_idx_reg;
        left_next      = left_reg;
        pend_next      = 1'b0;
        hit_next       = hit_reg;
        mem_we         = 1'b0;
        wr_addr        = ring_dec(front_idx_reg);
        rd_addr        = scan_idx_reg;

        if (state_reg == ST_IDLE)
        begin
            rd_addr = ring_inc(front_idx_reg);
        end

        if (take)
        begin
            cmd_next      = cmd;
            count_next    = cmd_count;
            hit_next      = 1'b0;
            scan_idx_next = front_idx_reg;
            left_next     = cmd_count;
            case (cmd.op)
                OP_PUSH_FRONT:
                begin
                    mem_we         = 1'b1;
                    wr_addr        = ring_dec(front_idx_reg);
                    front_idx_next = wr_addr;
                    front_key_next = cmd.key;
                    if (was_empty)
                    begin
                        back_idx_next = wr_addr;
                        back_key_next = cmd.key;
                    end
                end
                OP_PUSH_BACK:
                begin
                    mem_we        = 1'b1;
                    wr_addr       = was_empty ? front_idx_reg : ring_inc(back_idx_reg);
                    back_idx_next = wr_addr;
                    back_key_next = cmd.key;
                    if (was_empty)
                    begin
                        front_key_next = cmd.key;
                    end
                end
                OP_POP:
                begin
                    front_idx_next = ring_inc(front_idx_reg);
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end

        if (state_reg == ST_POP_WAIT)
        begin
            front_key_next = rd_data_reg;
        end

        if (state_reg == ST_SEARCH)
        begin
            if (left_reg != '0)
            begin
                scan_idx_next = ring_inc(scan_idx_reg);
                left_next     = left_reg - 1'b1;
                pend_next     = 1'b1;
            end
            if (pend_reg && (rd_data_reg == cmd_reg.key))
            begin
                hit_next = 1'b1;
            end
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= cmd.key;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        scan_idx_reg <= scan_idx_next;
        hit_reg      <= hit_next;
        if (load_out)
        begin
            found_out_reg <= hit_reg && (cmd_reg.op == OP_SEARCH);
            count_out_reg <= count_reg;
            front_out_reg <= (count_reg == '0) ? '0 : front_key_reg;
            back_out_reg  <= (count_reg == '0) ? '0 : back_key_reg;
            err_out_reg   <= cmd_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            front_idx_reg <= '0;
            back_idx_reg  <= '0;
            front_key_reg <= '0;
            back_key_reg  <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            front_idx_reg <= front_idx_next;
            back_idx_reg  <= back_idx_next;
            front_key_reg <= front_key_next;
            back_key_reg  <= back_key_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign response.valid     = out_valid_reg;
    assign response.found     = found_out_reg;
    assign response.count     = count_out_reg;
    assign response.front_key = front_out_reg;
    assign response.back_key  = back_out_reg;
    assign response.error     = err_out_reg;

endmodule

FILE: rtl/core/bounded_deque_with_search.sv
// Bounded deque of up to DEPTH signed 32-bit keys with push front, push back,
// pop front and linear search; every request word yields one response word
// with the search hit, the count, the front and back keys (0 when empty) and
// an error code. A classifier checks full and empty at the request side and
// feeds a two-entry queue, so requests are taken while the executor works and
// a response waits. The executor handles one word at a time: a pop makes one
// registered read of the ring store for the new front key, and a search scan
// reads one stored key per cycle through the store's single read port. The
// store needs no clearing after reset.
module bounded_deque_with_search
    import bdqs_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    bdqs_req_if.sink   request,
    bdqs_rsp_if.source response
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int QW = $bits(cmd_t) + CW;

    logic          front_valid;
    logic          q_wr_ready;
    cmd_t          front_cmd;
    logic [CW-1:0] front_count;
    logic          q_rd_valid;
    logic          q_rd_ready;
    logic [QW-1:0] q_rd_data;
    cmd_t          exec_cmd;
    logic [CW-1:0] exec_count;

    bdqs_front #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd_valid (front_valid),
        .cmd_ready (q_wr_ready),
        .cmd       (front_cmd),
        .cmd_count (front_count)
    );

    bdqs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (q_wr_ready),
        .wr_data  ({front_cmd, front_count}),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    assign exec_cmd   = q_rd_data[QW-1:CW];
    assign exec_count = q_rd_data[CW-1:0];

    bdqs_exec #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .IW    (IW)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_rd_valid),
        .cmd_ready (q_rd_ready),
        .cmd       (exec_cmd),
        .cmd_count (exec_count),
        .response  (response)
    );

endmodule

FILE: dv/tb_bounded_deque_with_search.sv
// testbench for bounded_deque_with_search: directed table plus random deque traffic, self-checked
module tb_bounded_deque_with_search
    import bdqs_pkg::*;
();

    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int HOLD_LEN   = 80;
    localparam int RAND_OPS   = 540;
    localparam int NUM_ROWS   = 22;

    typedef struct packed {
        logic               found;
        logic [4:0]         count;
        logic signed [31:0] front_key;
        logic signed [31:0] back_key;
        err_t               error;
    } deque_status_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
        logic [4:0]         reps;
        logic               typed;
        deque_status_t      want;
    } stim_row_t;

    localparam deque_status_t ANY = '0;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{KIND_POP_FRONT,  32'sd0,          5'd1,  1'b1, '{1'b0, 5'd0, 32'sd0, 32'sd0, ERR_EMPTY}},
        '{KIND_SEARCH,     32'sd0,          5'd1,  1'b1, '{1'b0, 5'd0, 32'sd0, 32'sd0, ERR_OK}},
        '{KIND_PUSH_BACK,  32'sh7fffffff,   5'd1,  1'b1,
          '{1'b0, 5'd1, 32'sh7fffffff, 32'sh7fffffff, ERR_OK}},
        '{KIND_PUSH_FRONT, 32'sh80000000,   5'd1,  1'b1,
          '{1'b0, 5'd2, 32'sh80000000, 32'sh7fffffff, ERR_OK}},
        '{KIND_SEARCH,     32'sh7fffffff,   5'd1,  1'b1,
          '{1'b1, 5'd2, 32'sh80000000, 32'sh7fffffff, ERR_OK}},
        '{KIND_SEARCH,     32'sh80000000,   5'd1,  1'b1,
          '{1'b1, 5'd2, 32'sh80000000, 32'sh7fffffff, ERR_OK}},
        '{KIND_SEARCH,     32'shffffffff,   5'd1,  1'b1,
          '{1'b0, 5'd2, 32'sh80000000, 32'sh7fffffff, ERR_OK}},
        '{KIND_SEARCH,     32'sd0,          5'd1,  1'b1,
          '{1'b0, 5'd2, 32'sh80000000, 32'sh7fffffff, ERR_OK}},
        '{KIND_POP_FRONT,  32'sh12345678,   5'd1,  1'b1,
          '{1'b0, 5'd1, 32'sh7fffffff, 32'sh7fffffff, ERR_OK}},
        '{KIND_POP_FRONT,  32'shffffffff,   5'd1,  1'b1, '{1'b0, 5'd0, 32'sd0, 32'sd0, ERR_OK}},
        '{KIND_POP_FRONT,  32'sd0,          5'd1,  1'b1, '{1'b0, 5'd0, 32'sd0, 32'sd0, ERR_EMPTY}},
        '{KIND_PUSH_FRONT, 32'sd5,          5'd1,  1'b1, '{1'b0, 5'd1, 32'sd5, 32'sd5, ERR_OK}},
        '{KIND_PUSH_FRONT, 32'sd6,          5'd1,  1'b1, '{1'b0, 5'd2, 32'sd6, 32'sd5, ERR_OK}},
        '{KIND_PUSH_BACK,  32'sd100,        5'd14, 1'b0, ANY},
        '{KIND_PUSH_BACK,  32'shffffffff,   5'd1,  1'b1, '{1'b0, 5'd16, 32'sd6, 32'sd113, ERR_FULL}},
        '{KIND_PUSH_FRONT, 32'shaaaa5555,   5'd1,  1'b1, '{1'b0, 5'd16, 32'sd6, 32'sd113, ERR_FULL}},
        '{KIND_SEARCH,     32'sd113,        5'd1,  1'b1, '{1'b1, 5'd16, 32'sd6, 32'sd113, ERR_OK}},
        '{KIND_SEARCH,     32'sd5,          5'd1,  1'b1, '{1'b1, 5'd16, 32'sd6, 32'sd113, ERR_OK}},
        '{KIND_SEARCH,     32'sh55555555,   5'd1,  1'b0, ANY},
        '{KIND_POP_FRONT,  32'sh55555555,   5'd16, 1'b0, ANY},
        '{KIND_POP_FRONT,  32'sd0,          5'd1,  1'b1, '{1'b0, 5'd0, 32'sd0, 32'sd0, ERR_EMPTY}},
        '{KIND_SEARCH,     32'shaaaaaaaa,   5'd1,  1'b1, '{1'b0, 5'd0, 32'sd0, 32'sd0, ERR_OK}}
    };

    logic clk = 1'b0;
    logic rst_n;

    bdqs_req_if req_ch ();
    bdqs_rsp_if #(.COUNT_W(5)) rsp_ch ();

    bounded_deque_with_search #(
        .DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // shadow copy of the deque
    logic signed [31:0] shadow_keys [DEPTH];
    logic [IDX_W-1:0]   shadow_head;
    logic [4:0]         shadow_fill;

    deque_status_t pending_status [$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_pending;
    int mismatch_count;
    int word_count;
    int search_count;
    int hit_count;
    int full_rejects;
    int empty_rejects;
    int peak_fill;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic deque_status_t deque_apply(input kind_t kind,
                                                  input logic signed [31:0] key);
        deque_status_t    st;
        logic [IDX_W-1:0] slot;
        st = '0;
        st.error = ERR_OK;
        case (kind)
            KIND_PUSH_FRONT:
            begin
                if (shadow_fill == DEPTH)
                    st.error = ERR_FULL;
                else
                begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_keys[shadow_head] = key;
                    shadow_fill = shadow_fill + 1'b1;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (shadow_fill == DEPTH)
                    st.error = ERR_FULL;
                else
                begin
                    slot = shadow_head + shadow_fill[IDX_W-1:0];
                    shadow_keys[slot] = key;
                    shadow_fill = shadow_fill + 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (shadow_fill == 0)
                    st.error = ERR_EMPTY;
                else
                begin
                    shadow_head = shadow_head + 1'b1;
                    shadow_fill = shadow_fill - 1'b1;
                end
            end
            default:
            begin
                for (int i = 0; i < shadow_fill; i++)
                begin
                    slot = shadow_head + i[IDX_W-1:0];
                    if (shadow_keys[slot] == key)
                        st.found = 1'b1;
                end
            end
        endcase
        st.count = shadow_fill;
        if (shadow_fill != 0)
        begin
            slot = shadow_head + (shadow_fill[IDX_W-1:0] - 1'b1);
            st.front_key = shadow_keys[shadow_head];
            st.back_key = shadow_keys[slot];
        end
        return st;
    endfunction

    task automatic send_word(input kind_t kind, input logic signed [31:0] value,
                             input logic typed, input deque_status_t want);
        deque_status_t st;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        st = deque_apply(kind, value);
        pending_status.insert(pending_status.size(), typed ? want : st);
        word_count++;
        if (kind == KIND_SEARCH)
        begin
            search_count++;
            if (st.found)
                hit_count++;
        end
        if (st.error == ERR_FULL)
            full_rejects++;
        if (st.error == ERR_EMPTY)
            empty_rejects++;
        if (st.count > peak_fill)
            peak_fill = st.count;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_status.size() != 0);
    endtask

    task automatic send_random_word(input int bias);
        kind_t              kind;
        logic signed [31:0] key;
        logic [IDX_W-1:0]   slot;
        int                 pick;
        pick = $urandom_range(0, 99);
        case (bias)
            0:       kind = pick < 45 ? KIND_PUSH_BACK : pick < 70 ? KIND_PUSH_FRONT :
                            pick < 85 ? KIND_POP_FRONT : KIND_SEARCH;
            1:       kind = pick < 15 ? KIND_PUSH_BACK : pick < 25 ? KIND_PUSH_FRONT :
                            pick < 70 ? KIND_POP_FRONT : KIND_SEARCH;
            default: kind = kind_t'(pick % 4);
        endcase
        key = $urandom;
        if ($urandom_range(0, 99) < 30)
        begin
            case ($urandom_range(0, 5))
                0:       key = 32'sd0;
                1:       key = 32'sd1;
                2:       key = -32'sd1;
                3:       key = 32'sh80000000;
                4:       key = 32'sh7fffffff;
                default: key = $urandom_range(0, 7);
            endcase
        end
        // when the deque holds keys, about half the searches look for a key that is stored
        if (kind == KIND_SEARCH && shadow_fill != 0 && $urandom_range(0, 1))
        begin
            slot = shadow_head + IDX_W'($urandom_range(0, shadow_fill - 1));
            key = shadow_keys[slot];
        end
        send_word(kind, key, 1'b0, ANY);
    endtask

    // response side
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_LEN)
                    @(posedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : rsp_check
        deque_status_t got;
        deque_status_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.found, rsp_ch.count, rsp_ch.front_key, rsp_ch.back_key,
                    err_t'(rsp_ch.error)};
            if (pending_status.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected word: found=%0b count=%0d front=%0d back=%0d err=%0d",
                             got.found, got.count, got.front_key, got.back_key, got.error);
                mismatch_count++;
            end
            else
            begin
                want = pending_status[0];
                pending_status.delete(0);
                if (got !== want)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("mismatch: exp found=%0b count=%0d front=%0d back=%0d err=%0d",
                                 want.found, want.count, want.front_key, want.back_key,
                                 want.error);
                        $display("          got found=%0b count=%0d front=%0d back=%0d err=%0d",
                                 got.found, got.count, got.front_key, got.back_key,
                                 got.error);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("bounded_deque_with_search test failed");
        $finish;
    end

    initial
    begin
        int bias;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_PUSH_FRONT;
        req_ch.value = '0;
        hold_pending = 1'b0;
        shadow_head = '0;
        shadow_fill = '0;
        for (int i = 0; i < DEPTH; i++)
            shadow_keys[i] = '0;
        mismatch_count = 0;
        word_count = 0;
        search_count = 0;
        hit_count = 0;
        full_rejects = 0;
        empty_rejects = 0;
        peak_fill = 0;
        send_idle_pct = 13;
        recv_idle_pct = 74;
        bias = 2;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[r])
            for (int n = 0; n < DIRECTED_ROWS[r].reps; n++)
                send_word(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].value + n,
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 13 : 0;
            for (int n = 0; n < RAND_OPS; n++)
            begin
                if (n % 48 == 0)
                    bias = $urandom_range(0, 2);
                // long receiver stall while words keep coming
                if (n == 100 && phase != 1)
                    hold_pending = 1'b1;
                if (n == RAND_OPS / 2)
                    wait_drained();
                send_random_word(bias);
            end
        end

        wait_drained();
        repeat (DEPTH + 8)
            @(posedge clk);
        if (pending_status.size() != 0)
        begin
            $display("%0d expected words never arrived", pending_status.size());
            mismatch_count += pending_status.size();
        end
        $display("covered %0d words: %0d searches (%0d hits), peak count %0d",
                 word_count, search_count, hit_count, peak_fill);
        $display("rejected %0d pushes on full and %0d pops on empty, %0d mismatches",
                 full_rejects, empty_rejects, mismatch_count);
        if (mismatch_count == 0)
            $display("bounded_deque_with_search test passed");
        else
            $display("bounded_deque_with_search test failed");
        $finish;
    end

endmodule
